### sv/mol_pkg.sv
`default_nettype none

package mol_pkg;

  // Field widths fixed by the stream format
  localparam int VALUE_FIELD_W = 32;
  localparam int IN_DATA_W     = 32;
  localparam int SIGN_W        = 2;
  localparam int COUNT_W       = 5;
  localparam int OUT_DATA_W    = 16;

  // Bit positions of the result fields in out_tdata
  localparam int MU_LSB   = 0;
  localparam int CNT_LSB  = MU_LSB + SIGN_W;
  localparam int LIOU_LSB = CNT_LSB + COUNT_W;
  localparam int OUT_USED = LIOU_LSB + SIGN_W;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

  // Two-bit signed codes for -1, 0 and +1
  localparam logic [SIGN_W-1:0] SIGN_ZERO  = 2'b00;
  localparam logic [SIGN_W-1:0] SIGN_PLUS  = 2'b01;
  localparam logic [SIGN_W-1:0] SIGN_MINUS = 2'b11;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

### sv/mol_div.sv
`default_nettype none

module mol_div #(
  parameter int WIDTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [WIDTH-1:0] dividend,
  input  wire logic [WIDTH-1:0] divisor,
  output logic                  done,
  output logic [WIDTH-1:0]      quotient,
  output logic [WIDTH-1:0]      remainder
);
  import mol_pkg::*;

  localparam int CNT_W = $clog2(WIDTH);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [WIDTH-1:0] rem_r, rem_nxt;
  logic [WIDTH-1:0] quo_r, quo_nxt;

  logic [WIDTH:0]   partial;
  logic [WIDTH:0]   diff;
  logic             fits;

  // One restoring step: bring down the next dividend bit, subtract if it fits
  assign partial = {rem_r, quo_r[WIDTH-1]};
  assign diff    = partial - {1'b0, divisor};
  assign fits    = !diff[WIDTH];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[WIDTH-1:0] : partial[WIDTH-1:0];
      quo_nxt = {quo_r[WIDTH-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(WIDTH - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

### sv/mobius_omega_liouville_unit.sv
// Moebius, big omega and Liouville values of one integer by trial division.
// Input stream: in_tdata carries the value; only its low VALUE_WIDTH bits
// count. Result stream: out_tdata carries the Moebius value, the prime
// factor count (saturating at 31) and the Liouville value, one result per
// request, in order.
// One request is worked on at a time; in_tready is high only while the
// factoring engine is free. Each trial division runs on a shared radix-2
// serial divider, one quotient bit per cycle. A request takes one division
// per trial divisor, up to and including the first one past the square
// root of the undivided part, plus one per prime factor taken out.
// For 32-bit primes near 2^32 this is about 65536 divisions.
// The result sits in an output register, so a new request is taken while
// a finished result waits; if the receiver stalls with a result still
// waiting, the engine holds its next result until that register frees.
// Reset (rst_n low at a clock edge) drops any request in progress and
// empties the output register.
`default_nettype none

module mobius_omega_liouville_unit #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // [31:0] value
  input  wire logic [mol_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // [1:0] mobius_value, [6:2] prime_factor_count, [8:7] liouville_value
  output logic [mol_pkg::OUT_DATA_W-1:0]      out_tdata
);
  import mol_pkg::*;

  localparam int W = VALUE_WIDTH;

  state_t state_r, state_nxt;

  logic [W-1:0]       rest_r, rest_nxt;
  logic [W-1:0]       d_r, d_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic               omega_par_r, omega_par_nxt;
  logic               mu_par_r, mu_par_nxt;
  logic               sqfree_r, sqfree_nxt;
  logic               inner_r, inner_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [SIGN_W-1:0]  out_mu_r, out_mu_nxt;
  logic [COUNT_W-1:0] out_cnt_r, out_cnt_nxt;
  logic [SIGN_W-1:0]  out_liou_r, out_liou_nxt;

  logic               in_fire;
  logic               div_start;
  logic               div_done;
  logic               out_load;
  logic [W-1:0]       div_quo;
  logic [W-1:0]       div_rem;
  logic [W-1:0]       in_value;
  logic               rem_zero;
  logic               past_root;
  logic               search_end;
  logic               rest_gt1;
  logic               fin_odd_mu;
  logic               fin_odd_omega;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
    sat_inc = (c == COUNT_MAX) ? COUNT_MAX : c + 1'b1;
  endfunction

  assign in_value   = VALUE_WIDTH'(in_tdata[VALUE_FIELD_W-1:0]);
  assign in_fire    = in_tvalid && in_tready;
  assign rem_zero   = (div_rem == '0);
  assign past_root  = (d_r > div_quo);
  assign search_end = div_done && !inner_r && past_root;
  assign rest_gt1   = (rest_r > W'(1));

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_fire) state_nxt = ST_DIV;
      ST_DIV:    if (search_end) state_nxt = ST_FINISH;
      ST_FINISH: if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_tready = (state_r == ST_IDLE);
    div_start = in_fire || ((state_r == ST_DIV) && div_done && !search_end);
    out_load  = (state_r == ST_FINISH) && (!out_valid_r || out_tready);
  end

  // Factoring datapath: decide after each division what to divide next
  always_comb begin
    rest_nxt      = rest_r;
    d_nxt         = d_r;
    count_nxt     = count_r;
    omega_par_nxt = omega_par_r;
    mu_par_nxt    = mu_par_r;
    sqfree_nxt    = sqfree_r;
    inner_nxt     = inner_r;
    if (in_fire) begin
      rest_nxt      = in_value;
      d_nxt         = W'(2);
      count_nxt     = '0;
      omega_par_nxt = 1'b0;
      mu_par_nxt    = 1'b0;
      sqfree_nxt    = 1'b1;
      inner_nxt     = 1'b0;
    end else if ((state_r == ST_DIV) && div_done && !search_end) begin
      if (rem_zero) begin
        // divisor found: take it out and try the same divisor again
        rest_nxt      = div_quo;
        count_nxt     = sat_inc(count_r);
        omega_par_nxt = !omega_par_r;
        if (inner_r) begin
          sqfree_nxt = 1'b0;
        end else begin
          mu_par_nxt = !mu_par_r;
          inner_nxt  = 1'b1;
        end
      end else begin
        // advance to the next trial divisor
        d_nxt     = d_r + 1'b1;
        inner_nxt = 1'b0;
      end
    end
  end

  // The divider loads its dividend at start; the divisor is read while busy
  mol_div #(
    .WIDTH (W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (rest_nxt),
    .divisor   (d_r),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Final result: a leftover above one is one more prime
  assign fin_odd_mu    = mu_par_r ^ rest_gt1;
  assign fin_odd_omega = omega_par_r ^ rest_gt1;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_mu_nxt    = out_mu_r;
    out_cnt_nxt   = out_cnt_r;
    out_liou_nxt  = out_liou_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_mu_nxt    = !sqfree_r ? SIGN_ZERO : (fin_odd_mu ? SIGN_MINUS : SIGN_PLUS);
      out_cnt_nxt   = rest_gt1 ? sat_inc(count_r) : count_r;
      out_liou_nxt  = fin_odd_omega ? SIGN_MINUS : SIGN_PLUS;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rest_r      <= rest_nxt;
    d_r         <= d_nxt;
    count_r     <= count_nxt;
    omega_par_r <= omega_par_nxt;
    mu_par_r    <= mu_par_nxt;
    sqfree_r    <= sqfree_nxt;
    inner_r     <= inner_nxt;
    out_mu_r    <= out_mu_nxt;
    out_cnt_r   <= out_cnt_nxt;
    out_liou_r  <= out_liou_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - OUT_USED)'(0), out_liou_r, out_cnt_r, out_mu_r};

endmodule

`default_nettype wire

### sv/mol_chk.sv
`default_nettype none

module mol_chk (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_tvalid,
  input wire logic                           in_tready,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [mol_pkg::OUT_DATA_W-1:0] out_tdata
);
  import mol_pkg::*;

  logic [SIGN_W-1:0]  mu;
  logic [COUNT_W-1:0] cnt;
  logic [SIGN_W-1:0]  liou;

  assign mu   = out_tdata[MU_LSB +: SIGN_W];
  assign cnt  = out_tdata[CNT_LSB +: COUNT_W];
  assign liou = out_tdata[LIOU_LSB +: SIGN_W];

  // one request at a time: drop ready once a request is taken
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while another is in progress");

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed or vanished");

  // Liouville sign follows the parity of an unsaturated count
  a_liou_parity: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (cnt != COUNT_MAX) |->
      (liou == (cnt[0] ? SIGN_MINUS : SIGN_PLUS)))
    else $error("Liouville sign disagrees with factor count");

  // a squarefree value has as many distinct primes as primes
  a_mu_liou: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (mu != SIGN_ZERO) |-> (mu == liou))
    else $error("Moebius sign disagrees with Liouville sign");

  // a non-squarefree value has at least two prime factors
  a_mu_zero_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (mu == SIGN_ZERO) |-> (cnt >= COUNT_W'(2)))
    else $error("zero Moebius value with fewer than two factors");

endmodule

bind mobius_omega_liouville_unit mol_chk u_mol_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

### verif/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mol_pkg::*;

  localparam int          RANDOM_REQUESTS = 100;
  localparam longint      CYCLE_LIMIT     = 3_000_000;

  // One expected factoring result, fields as carried in out_tdata
  typedef struct packed {
    logic [SIGN_W-1:0]  mobius;
    logic [COUNT_W-1:0] count;
    logic [SIGN_W-1:0]  liouville;
  } factoring_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;

  logic [IN_DATA_W-1:0] values_to_send[$];
  factoring_t           awaited_factorings[$];

  int     total_requests;
  int     directed_requests;
  int     accepted_requests;
  int     checked_results;
  int     error_count;
  int     mobius_minus_seen;
  int     mobius_zero_seen;
  int     mobius_plus_seen;
  int     widest_count_seen;
  longint cycle_count;
  logic   req_taken;

  // Sender burst shaping and receiver stall pattern
  int burst_left;
  int gap_left;
  int ready_left;
  int stall_left;

  mobius_omega_liouville_unit #(
    .VALUE_WIDTH(32)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Factor by trial division and derive Moebius, big omega and Liouville
  function automatic factoring_t predict_factoring(input logic [IN_DATA_W-1:0] value);
    longint unsigned rest;
    longint unsigned divisor;
    longint unsigned mult;
    longint unsigned prime_total;
    longint unsigned distinct;
    bit              square_free;
    factoring_t      res;
    rest        = 64'(value);
    prime_total = 0;
    distinct    = 0;
    square_free = 1'b1;
    for (divisor = 2; divisor <= rest / divisor; divisor++) begin
      if (rest % divisor == 0) begin
        mult = 0;
        while (rest % divisor == 0) begin
          rest = rest / divisor;
          mult++;
        end
        distinct++;
        prime_total += mult;
        if (mult > 1) square_free = 1'b0;
      end
    end
    // leftover above one is a single large prime
    if (rest > 1) begin
      distinct++;
      prime_total++;
    end
    if (!square_free) res.mobius = SIGN_ZERO;
    else res.mobius = distinct[0] ? SIGN_MINUS : SIGN_PLUS;
    res.count     = (prime_total > 64'(COUNT_MAX)) ? COUNT_MAX : prime_total[COUNT_W-1:0];
    res.liouville = prime_total[0] ? SIGN_MINUS : SIGN_PLUS;
    return res;
  endfunction

  task automatic check_field(input string label, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
      error_count++;
    end
  endtask

  // Build the request list: directed corner values, then random ones
  initial begin
    longint unsigned smooth;
    longint unsigned prime;
    int              kind;
    int unsigned     small_primes[25];

    small_primes = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41,
                     43, 47, 53, 59, 61, 67, 71, 73, 79, 83, 89, 97};

    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;

    // zero, one, tiny primes, a square and small composites
    values_to_send.push_back(32'd0);
    values_to_send.push_back(32'd1);
    values_to_send.push_back(32'd2);
    values_to_send.push_back(32'd3);
    values_to_send.push_back(32'd4);
    values_to_send.push_back(32'd6);
    values_to_send.push_back(32'd12);
    values_to_send.push_back(32'd30030);
    // nine distinct primes, squarefree with odd parity
    values_to_send.push_back(32'd223092870);
    // all ones and alternating patterns: products of Fermat primes, the last one doubled
    values_to_send.push_back(32'hFFFF_FFFF);
    values_to_send.push_back(32'h5555_5555);
    values_to_send.push_back(32'hAAAA_AAAA);
    // widest count the field holds: 2^31; then 3^20
    values_to_send.push_back(32'h8000_0000);
    values_to_send.push_back(32'd3486784401);
    // squares of composite and prime, larger primes and 2^16
    values_to_send.push_back(32'd4294836225);
    values_to_send.push_back(32'd9409);
    values_to_send.push_back(32'd65521);
    values_to_send.push_back(32'd1000003);
    values_to_send.push_back(32'd65536);
    directed_requests = values_to_send.size();

    // Random part: small values, smooth values across all 32 bits, mid values
    repeat (RANDOM_REQUESTS) begin
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        values_to_send.push_back($urandom_range(0, 4095));
      end else if (kind < 8) begin
        smooth = 1;
        repeat ($urandom_range(1, 32)) begin
          prime = 64'(small_primes[$urandom_range(0, 24)]);
          if (smooth * prime <= 64'hFFFF_FFFF) smooth = smooth * prime;
        end
        values_to_send.push_back(smooth[IN_DATA_W-1:0]);
      end else begin
        values_to_send.push_back($urandom_range(0, 65535));
      end
    end
    total_requests = values_to_send.size();

    // Hold reset, then release it on a falling edge
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Drain: everything accepted, every result back, then a short margin
    wait (accepted_requests == total_requests);
    wait (awaited_factorings.size() == 0);
    repeat (16) @(posedge clk);

    $display("Sent %0d requests (%0d directed, %0d random), checked %0d results.",
             total_requests, directed_requests, total_requests - directed_requests,
             checked_results);
    $display("Moebius -1/0/+1 seen %0d/%0d/%0d times, widest factor count %0d.",
             mobius_minus_seen, mobius_zero_seen, mobius_plus_seen, widest_count_seen);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Driver: hold a request until taken, send in bursts with random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      burst_left <= $urandom_range(1, 8);
      gap_left   <= 0;
    end else if (in_tvalid && !req_taken) begin
      in_tvalid <= 1'b1;
    end else if (gap_left > 0) begin
      in_tvalid <= 1'b0;
      gap_left  <= gap_left - 1;
    end else if (values_to_send.size() > 0) begin
      in_tvalid <= 1'b1;
      in_tdata  <= values_to_send.pop_front();
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 8);
        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // Receiver: alternate ready runs and stalls of random length
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      ready_left <= $urandom_range(1, 40);
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (ready_left > 0) begin
      out_tready <= 1'b1;
      ready_left <= ready_left - 1;
    end else begin
      out_tready <= 1'b0;
      ready_left <= $urandom_range(1, 60);
      stall_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40)
                                                : $urandom_range(0, 6);
    end
  end

  // Monitor: predict on each accepted request, check each accepted result
  always @(posedge clk) begin
    factoring_t want;
    req_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      awaited_factorings.push_back(predict_factoring(in_tdata));
      accepted_requests <= accepted_requests + 1;
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited_factorings.size() == 0) begin
        $display("%0t: result with none expected, actual %h", $time, out_tdata);
        error_count++;
      end else begin
        want = awaited_factorings.pop_front();
        check_field("mobius_value", 32'(want.mobius),
                    32'(out_tdata[MU_LSB +: SIGN_W]));
        check_field("prime_factor_count", 32'(want.count),
                    32'(out_tdata[CNT_LSB +: COUNT_W]));
        check_field("liouville_value", 32'(want.liouville),
                    32'(out_tdata[LIOU_LSB +: SIGN_W]));
        check_field("padding", 0, 32'(out_tdata[OUT_DATA_W-1:OUT_USED]));
        checked_results++;
        if (want.mobius == SIGN_MINUS) mobius_minus_seen++;
        else if (want.mobius == SIGN_ZERO) mobius_zero_seen++;
        else mobius_plus_seen++;
        if (int'(want.count) > widest_count_seen) widest_count_seen = int'(want.count);
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run limit reached with %0d results outstanding", $time,
               awaited_factorings.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    cycle_count       = 0;
    req_taken         = 1'b0;
    accepted_requests = 0;
    checked_results   = 0;
    error_count       = 0;
    mobius_minus_seen = 0;
    mobius_zero_seen  = 0;
    mobius_plus_seen  = 0;
    widest_count_seen = 0;
  end

endmodule
